// ===== src/bdcl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bdcl_pkg;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PRESS_LEVEL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_NORMAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_FAST   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_MODE       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_ENABLE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_INITIAL    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_REPEAT     = 3'd7;

  localparam logic [CFG_DATA_W-1:0] RST_DEBOUNCE_MS     = 16'd50;
  localparam logic [CFG_DATA_W-1:0] RST_COOLDOWN_NORMAL = 16'd200;
  localparam logic [CFG_DATA_W-1:0] RST_COOLDOWN_FAST   = 16'd50;
  localparam logic [CFG_DATA_W-1:0] RST_LONG_INITIAL    = 16'd500;
  localparam logic [CFG_DATA_W-1:0] RST_LONG_REPEAT     = 16'd100;

  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

endpackage

`default_nettype wire

// ===== src/bdcl_tick_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bdcl_tick_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink (input valid, input pin_level, output ready);
endinterface

`default_nettype wire

// ===== src/bdcl_result_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bdcl_result_if;
  logic valid;
  logic ready;
  logic click;
  logic hold_repeat;
  logic held;
  logic in_debounce;

  modport source (output valid, output click, output hold_repeat, output held,
                  output in_debounce, input ready);
  modport sink (input valid, input click, input hold_repeat, input held,
                input in_debounce, output ready);
endinterface

`default_nettype wire

// ===== src/button_debounce_click_longpress_core.sv =====
// Channel     Dir  Payload                                 Transfer
// tick_in     in   pin_level                               valid & ready
// result_out  out  click, hold_repeat, held, in_debounce   valid & ready
// cfg         in   cfg_idx, cfg_data                       cfg_we
//
// One tick per cycle while tick_in.ready is high: state and result register update in the transfer cycle.
// A result appears in the cycle after its tick transfers; it is held in the result register.
// tick_in.ready is high while the result register is empty or being drained.
// rst is synchronous: configuration returns to its defaults, state returns to idle.
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_click_longpress_core #(
  parameter int unsigned CHECK_PERIOD_TICKS = 50,
  parameter int unsigned TIME_BITS          = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire bdcl_pkg::cfg_idx_t  cfg_idx,
  input  wire bdcl_pkg::cfg_data_t cfg_data,
  bdcl_tick_if.sink              tick_in,
  bdcl_result_if.source          result_out
);
  import bdcl_pkg::*;

  localparam int unsigned PHASE_W =
    ($clog2(CHECK_PERIOD_TICKS + 1) < 1) ? 1 : $clog2(CHECK_PERIOD_TICKS + 1);
  localparam int unsigned CMP_W = (TIME_BITS > CFG_DATA_W) ? TIME_BITS : CFG_DATA_W;
  localparam logic [PHASE_W-1:0] PERIOD = PHASE_W'(CHECK_PERIOD_TICKS);

  typedef logic [TIME_BITS-1:0] time_t;

  function automatic time_t sat_inc(input time_t v);
    return (v == '1) ? v : v + time_t'(1);
  endfunction

  // configuration
  logic      press_level;
  cfg_data_t debounce_ms;
  cfg_data_t cooldown_normal_ms;
  cfg_data_t cooldown_fast_ms;
  logic      fast_mode;
  logic      hold_repeat_en;
  cfg_data_t long_initial_ms;
  cfg_data_t long_repeat_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      press_level        <= 1'b0;
      debounce_ms        <= RST_DEBOUNCE_MS;
      cooldown_normal_ms <= RST_COOLDOWN_NORMAL;
      cooldown_fast_ms   <= RST_COOLDOWN_FAST;
      fast_mode          <= 1'b0;
      hold_repeat_en     <= 1'b0;
      long_initial_ms    <= RST_LONG_INITIAL;
      long_repeat_ms     <= RST_LONG_REPEAT;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_PRESS_LEVEL:     press_level        <= cfg_data[0];
        REG_DEBOUNCE_MS:     debounce_ms        <= cfg_data;
        REG_COOLDOWN_NORMAL: cooldown_normal_ms <= cfg_data;
        REG_COOLDOWN_FAST:   cooldown_fast_ms   <= cfg_data;
        REG_FAST_MODE:       fast_mode          <= cfg_data[0];
        REG_LONG_ENABLE:     hold_repeat_en     <= cfg_data[0];
        REG_LONG_INITIAL:    long_initial_ms    <= cfg_data;
        REG_LONG_REPEAT:     long_repeat_ms     <= cfg_data;
        default: ;
      endcase
    end
  end

  // tick state
  logic               prev_level, prev_level_next;
  logic               debouncing, debouncing_next;
  time_t              debounce_count, debounce_count_next;
  logic               pressed, pressed_next;
  time_t              hold_ticks, hold_ticks_next;
  time_t              since_repeat, since_repeat_next;
  time_t              since_click, since_click_next;
  logic               check_running, check_running_next;
  logic [PHASE_W-1:0] check_phase, check_phase_next;
  logic               click_next, hold_repeat_next;

  logic               res_valid;
  logic               res_click, res_hold_repeat, res_held, res_in_debounce;
  logic               take;
  logic               level, active;
  logic [PHASE_W-1:0] phase_inc;
  time_t              dc_inc;
  cfg_data_t          cooldown;

  assign take          = tick_in.valid & tick_in.ready;
  assign tick_in.ready = ~res_valid | result_out.ready;
  assign level         = tick_in.pin_level;
  assign active        = (level == press_level);
  assign phase_inc     = check_phase + PHASE_W'(1);
  assign dc_inc        = sat_inc(debounce_count);
  assign cooldown      = fast_mode ? cooldown_fast_ms : cooldown_normal_ms;

  always_comb begin
    hold_ticks_next     = sat_inc(hold_ticks);
    since_repeat_next   = sat_inc(since_repeat);
    since_click_next    = sat_inc(since_click);
    check_phase_next    = check_phase;
    check_running_next  = check_running;
    pressed_next        = pressed;
    debouncing_next     = debouncing;
    debounce_count_next = debounce_count;
    click_next          = 1'b0;
    hold_repeat_next    = 1'b0;

    if (check_running) begin
      check_phase_next = phase_inc;
      if (phase_inc >= PERIOD) begin
        check_phase_next = '0;
        if (active && pressed &&
            CMP_W'(hold_ticks_next) >= CMP_W'(long_initial_ms) &&
            CMP_W'(since_repeat_next) >= CMP_W'(long_repeat_ms)) begin
          since_repeat_next = '0;
          hold_repeat_next  = 1'b1;
        end
      end
    end

    if (debouncing) begin
      debounce_count_next = dc_inc;
      if (CMP_W'(dc_inc) >= CMP_W'(debounce_ms)) begin
        if (active) begin
          if (hold_repeat_en) begin
            click_next = 1'b1;
          end else if (CMP_W'(since_click_next) >= CMP_W'(cooldown)) begin
            since_click_next = '0;
            click_next       = 1'b1;
          end
        end else begin
          pressed_next       = 1'b0;
          check_running_next = 1'b0;
        end
        debouncing_next     = 1'b0;
        debounce_count_next = '0;
      end
    end else if (level != prev_level) begin
      if (active) begin
        pressed_next      = 1'b1;
        hold_ticks_next   = '0;
        since_repeat_next = '0;
        if (hold_repeat_en) begin
          check_running_next = 1'b1;
          check_phase_next   = '0;
        end
        debouncing_next     = 1'b1;
        debounce_count_next = '0;
      end else begin
        pressed_next       = 1'b0;
        check_running_next = 1'b0;
      end
    end

    prev_level_next = level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level     <= 1'b1;
      debouncing     <= 1'b0;
      debounce_count <= '0;
      pressed        <= 1'b0;
      hold_ticks     <= '0;
      since_repeat   <= '0;
      since_click    <= '0;
      check_running  <= 1'b0;
      check_phase    <= '0;
    end else if (take) begin
      prev_level     <= prev_level_next;
      debouncing     <= debouncing_next;
      debounce_count <= debounce_count_next;
      pressed        <= pressed_next;
      hold_ticks     <= hold_ticks_next;
      since_repeat   <= since_repeat_next;
      since_click    <= since_click_next;
      check_running  <= check_running_next;
      check_phase    <= check_phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (result_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_click       <= click_next;
      res_hold_repeat <= hold_repeat_next;
      res_held        <= pressed_next;
      res_in_debounce <= debouncing_next;
    end
  end

  assign result_out.valid       = res_valid;
  assign result_out.click       = res_click;
  assign result_out.hold_repeat = res_hold_repeat;
  assign result_out.held        = res_held;
  assign result_out.in_debounce = res_in_debounce;

endmodule

`default_nettype wire

// ===== src/bdcl_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bdcl_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic click,
  input wire logic hold_repeat,
  input wire logic held,
  input wire logic in_debounce
);

  // hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(click) && $stable(hold_repeat)
      && $stable(held) && $stable(in_debounce))
    else $error("stalled result changed");

  a_click_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && click |-> held && !in_debounce)
    else $error("click without held button or with window open");

  a_window_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_debounce |-> held)
    else $error("debounce window open while released");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_one_per_tick: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> out_valid)
    else $error("tick transfer produced no result");

endmodule

bind button_debounce_click_longpress_core bdcl_checker u_bdcl_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (tick_in.valid),
  .in_ready    (tick_in.ready),
  .out_valid   (result_out.valid),
  .out_ready   (result_out.ready),
  .click       (result_out.click),
  .hold_repeat (result_out.hold_repeat),
  .held        (result_out.held),
  .in_debounce (result_out.in_debounce)
);

`default_nettype wire
